### rtl/core/lcts_pkg.sv
// lcts_pkg: types, constants and state codes for the load-cell tare and smoothing block
// no dependencies; imported by lcts_div, load_cell_tare_scale_smoother and tb
package lcts_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int TARE_SAMPLES_DEF = 4;
  localparam int WEIGHT_W         = 25;
  localparam int FP_W             = 7;
  localparam int SDIV_W           = 16;
  localparam int CFG_DATA_W       = 16;

  // divider magnitude width and divisor width
  localparam int DIV_W            = 32;
  localparam int DSR_W            = 16;
  localparam int DIV_CNT_W        = $clog2(DIV_W + 1);

  localparam logic [FP_W-1:0]   PERCENT_FULL  = 7'd100;
  localparam logic [FP_W-1:0]   FILTER_RESET  = 7'd10;
  localparam logic [SDIV_W-1:0] SCALE_RESET   = 16'd719;
  localparam logic signed [DIV_W:0] WEIGHT_MAX = 33'sd16777215;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_TARE    = 1'b1;

  // configuration register indexes
  localparam logic CFG_FILTER_PERCENT = 1'b0;
  localparam logic CFG_SCALE_DIVISOR  = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_value;
    logic                       tare_done;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W:0]   dividend;
    logic [DSR_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W:0]   quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TARE_WAIT,
    ST_MEAS_WAIT,
    ST_MUL_PREV,
    ST_MUL_X,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_OUT
  } lcts_state_t;

endpackage

### rtl/core/lcts_div.sv
// lcts_div: signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero; depends on lcts_pkg
module lcts_div
  import lcts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DSR_W-1:0]     rem_r, rem_nxt;
  logic [DSR_W-1:0]     dsr_r, dsr_nxt;

  logic signed [DIV_W:0] mag;
  logic [DSR_W:0]        shifted;
  logic [DSR_W+1:0]      diff;
  logic                  ge;

  always_comb begin
    mag      = req.dividend[DIV_W] ? -req.dividend : req.dividend;
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr_r};
    ge       = !diff[DSR_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[DIV_W];
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      quo_nxt  = mag[DIV_W-1:0];
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

### rtl/core/load_cell_tare_scale_smoother.sv
// load_cell_tare_scale_smoother: tare averaging, offset correction, scaling and smoothing
// timing: a tare request passes through one serial division, a measure request through a
// scaling division, two multiply steps and a mixing division; the divider does one bit a cycle over 32 bits
// throughput: one request at a time, next accepted the cycle after the result is registered
// reset (rst_n, synchronous): offset, tare sum, tare count and smoothed value cleared,
// filter_percent back to 10, scale_divisor back to 719; depends on lcts_pkg, lcts_div
module load_cell_tare_scale_smoother
  import lcts_pkg::*;
#(
  parameter int TARE_SAMPLES = TARE_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TCNT_W = 4;

  // sequencer
  lcts_state_t state_r, state_nxt;

  // configuration
  logic [FP_W-1:0]   filter_percent_r;
  logic [SDIV_W-1:0] scale_divisor_r;

  // model state
  logic signed [SAMPLE_BITS-1:0] tare_offset_r, tare_offset_nxt;
  logic signed [SAMPLE_BITS-1:0] tare_sum_r, tare_sum_nxt;
  logic [TCNT_W-1:0]             tare_count_r, tare_count_nxt;
  logic signed [WEIGHT_W-1:0]    prev_r, prev_nxt;
  logic                          done_r, done_nxt;

  // working registers
  logic signed [WEIGHT_W-1:0] x_r, x_nxt;
  logic signed [DIV_W:0]      acc_r, acc_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // shared units
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic signed [DIV_W:0] mul_a, mul_b, mul_res;
  logic [FP_W-1:0]       p_eff;
  logic [SDIV_W-1:0]     sdiv_eff;
  logic                  in_acc;
  logic                  out_free;
  logic [TCNT_W-1:0]     count_inc;
  logic signed [SAMPLE_BITS-1:0] sum_inc;

  lcts_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // clipped weight and guarded divisor
  assign p_eff    = (filter_percent_r > PERCENT_FULL) ? PERCENT_FULL : filter_percent_r;
  assign sdiv_eff = (scale_divisor_r == '0) ? SDIV_W'(1) : scale_divisor_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.req_type == REQ_TARE) ? ST_TARE_WAIT : ST_MEAS_WAIT;
        end
      end
      ST_TARE_WAIT: begin
        if (div_rsp.done) state_nxt = ST_OUT;
      end
      ST_MEAS_WAIT: begin
        if (div_rsp.done) state_nxt = ST_MUL_PREV;
      end
      ST_MUL_PREV: state_nxt = ST_MUL_X;
      ST_MUL_X:    state_nxt = ST_MIX_GO;
      ST_MIX_GO:   state_nxt = ST_MIX_WAIT;
      ST_MIX_WAIT: begin
        if (div_rsp.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = acc_r;
    div_req.divisor  = DSR_W'(PERCENT_FULL);
    mul_a            = (DIV_W+1)'(x_r);
    mul_b            = (DIV_W+1)'(p_eff);
    tare_offset_nxt  = tare_offset_r;
    tare_sum_nxt     = tare_sum_r;
    tare_count_nxt   = tare_count_r;
    prev_nxt         = prev_r;
    done_nxt         = done_r;
    x_nxt            = x_r;
    acc_nxt          = acc_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    count_inc        = tare_count_r + 1'b1;
    sum_inc          = tare_sum_r + div_rsp.quotient[SAMPLE_BITS-1:0];

    if (state_r == ST_MUL_PREV) begin
      mul_a = (DIV_W+1)'(prev_r);
      mul_b = (DIV_W+1)'(PERCENT_FULL - p_eff);
    end
    mul_res = mul_a * mul_b;

    case (state_r)
      ST_IDLE: begin
        // launch the first division straight from the request
        if (in_acc) begin
          div_req.start = 1'b1;
          done_nxt      = 1'b0;
          if (in_data.req_type == REQ_TARE) begin
            div_req.dividend = (DIV_W+1)'(in_data.raw_sample);
            div_req.divisor  = DSR_W'(TARE_SAMPLES);
          end else begin
            div_req.dividend = (DIV_W+1)'(in_data.raw_sample) - (DIV_W+1)'(tare_offset_r);
            div_req.divisor  = sdiv_eff;
          end
        end
      end
      ST_TARE_WAIT: begin
        if (div_rsp.done) begin
          // enough tare samples: sum becomes the offset
          if (count_inc >= TCNT_W'(TARE_SAMPLES)) begin
            tare_offset_nxt = sum_inc;
            tare_sum_nxt    = '0;
            tare_count_nxt  = '0;
            done_nxt        = 1'b1;
          end else begin
            tare_sum_nxt    = sum_inc;
            tare_count_nxt  = count_inc;
          end
        end
      end
      ST_MEAS_WAIT: begin
        if (div_rsp.done) x_nxt = div_rsp.quotient[WEIGHT_W-1:0];
      end
      ST_MUL_PREV: acc_nxt = mul_res;
      ST_MUL_X:    acc_nxt = acc_r + mul_res;
      ST_MIX_GO: begin
        div_req.start = 1'b1;
      end
      ST_MIX_WAIT: begin
        if (div_rsp.done) begin
          // clamp to the weight range
          if (div_rsp.quotient > WEIGHT_MAX) begin
            prev_nxt = WEIGHT_MAX[WEIGHT_W-1:0];
          end else if (div_rsp.quotient < -WEIGHT_MAX) begin
            prev_nxt = WEIGHT_W'(-WEIGHT_MAX);
          end else begin
            prev_nxt = div_rsp.quotient[WEIGHT_W-1:0];
          end
        end
      end
      ST_OUT: begin
        // hold the result here until the output register is free
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.weight_value = prev_r;
          out_data_nxt.tare_done    = done_r;
        end
      end
      default: ;
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      filter_percent_r <= FILTER_RESET;
      scale_divisor_r  <= SCALE_RESET;
      tare_offset_r    <= '0;
      tare_sum_r       <= '0;
      tare_count_r     <= '0;
      prev_r           <= '0;
      done_r           <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      tare_offset_r <= tare_offset_nxt;
      tare_sum_r    <= tare_sum_nxt;
      tare_count_r  <= tare_count_nxt;
      prev_r        <= prev_nxt;
      done_r        <= done_nxt;
      // configuration request
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER_PERCENT: filter_percent_r <= cfg_data[FP_W-1:0];
          CFG_SCALE_DIVISOR:  scale_divisor_r  <= cfg_data[SDIV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for load_cell_tare_scale_smoother, with a directed table then random phases
// depends on lcts_pkg (request/result structs, register indexes, reset values) and the block's rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcts_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 11;
  // idle cycles (nothing moving on any channel) before the run is declared hung
  localparam int QUIET_LIMIT     = 4000;
  // settle time after the drain, so that any late stray result is still seen
  localparam int SETTLE_CYCLES   = 100;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int MAX_PRINTS      = 40;

  typedef enum bit {ROW_SAMPLE, ROW_REG} row_kind_e;

  // one line of the directed table: either a sample request or a register write
  typedef struct {
    row_kind_e   kind;
    in_item_t    rq;
    logic        reg_idx;
    logic [15:0] reg_val;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FILTER_PERCENT;
  logic [15:0] cfg_data = '0;

  load_cell_tare_scale_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // bench copy of the block's registers and state, starting at their reset values
  logic [FP_W-1:0]               mix_pct       = FILTER_RESET;
  logic [SDIV_W-1:0]             counts_per_mg = SCALE_RESET;
  logic signed [SAMPLE_BITS-1:0] zero_offset   = '0;
  logic signed [SAMPLE_BITS-1:0] tare_accum    = '0;
  logic [3:0]                    tare_seen     = '0;
  logic signed [WEIGHT_W-1:0]    smooth_hold   = '0;

  // results owed by the block, oldest first
  out_item_t awaited_weights[$];

  // a directed row with a hand-written expectation arms this before its request goes out
  bit        typed_armed = 1'b0;
  out_item_t typed_want;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  int err_count    = 0;
  int samples_in   = 0;
  int tare_in      = 0;
  int offsets_made = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int quiet        = 0;

  // works out the result of one sample request and moves the bench state on
  function automatic out_item_t weigh_request(in_item_t rq);
    longint    raw;
    longint    part;
    longint    dv;
    longint    pct;
    longint    x;
    longint    mix;
    out_item_t res;
    raw = longint'($signed(rq.raw_sample));
    res.tare_done = 1'b0;
    if (rq.req_type == REQ_TARE) begin
      // each tare reading is pre-divided, truncating toward zero, then summed
      part = raw / TARE_SAMPLES_DEF;
      tare_accum = tare_accum + SAMPLE_BITS'(part);
      tare_seen = tare_seen + 4'd1;
      if (tare_seen >= TARE_SAMPLES_DEF) begin
        zero_offset = tare_accum;
        tare_accum = '0;
        tare_seen = '0;
        res.tare_done = 1'b1;
      end
    end else begin
      // a zero divisor behaves as one, a percentage above full behaves as full
      dv = (counts_per_mg == '0) ? 64'sd1 : longint'(counts_per_mg);
      pct = (mix_pct > PERCENT_FULL) ? longint'(PERCENT_FULL) : longint'(mix_pct);
      x = (raw - longint'(zero_offset)) / dv;
      mix = (longint'(smooth_hold) * (longint'(PERCENT_FULL) - pct) + x * pct)
            / longint'(PERCENT_FULL);
      if (mix > longint'(WEIGHT_MAX)) mix = longint'(WEIGHT_MAX);
      if (mix < -longint'(WEIGHT_MAX)) mix = -longint'(WEIGHT_MAX);
      smooth_hold = WEIGHT_W'(mix);
    end
    res.weight_value = smooth_hold;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic in_item_t make_req(logic kind_bit, int raw);
    in_item_t rq;
    rq.req_type = kind_bit;
    rq.raw_sample = SAMPLE_BITS'(raw);
    return rq;
  endfunction

  function automatic dir_row_t free_row(logic kind_bit, int raw);
    dir_row_t r;
    r.kind = ROW_SAMPLE;
    r.rq = make_req(kind_bit, raw);
    r.reg_idx = CFG_FILTER_PERCENT;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic kind_bit, int raw, int w, logic dn);
    dir_row_t r;
    r = free_row(kind_bit, raw);
    r.typed = 1'b1;
    r.want.weight_value = WEIGHT_W'(w);
    r.want.tare_done = dn;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic idx, int val);
    dir_row_t r;
    r = free_row(REQ_MEASURE, 0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = 16'(val);
    return r;
  endfunction

  // random sample: mostly full range, some extremes, some close to the current offset
  function automatic int pick_raw();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return 8388607;
        1: return -8388608;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (sel <= 3) return int'(zero_offset) + int'($urandom_range(0, 4000)) - 2000;
    return int'($urandom);
  endfunction

  // receiver side: random stall decided once per cycle at the falling edge
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // scoreboard: predicts on each accepted request, checks each accepted result,
  // keeps the register copy in step and watches for a hung handshake
  always @(posedge clk) begin
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FILTER_PERCENT) mix_pct = cfg_data[FP_W-1:0];
        else counts_per_mg = cfg_data[SDIV_W-1:0];
        cfg_writes++;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        want = weigh_request(in_data);
        // a hand-written expectation takes the place of the predicted one
        if (typed_armed) begin
          want = typed_want;
          typed_armed = 1'b0;
        end
        awaited_weights.push_back(want);
        samples_in++;
        if (in_data.req_type == REQ_TARE) tare_in++;
        if (want.tare_done) offsets_made++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        moved = 1'b1;
        if (awaited_weights.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing awaited", results_seen));
        end else begin
          want = awaited_weights.pop_front();
          if (out_data.weight_value !== want.weight_value)
            report_mismatch($sformatf("result %0d weight_value %0d, expected %0d", results_seen,
                                      out_data.weight_value, want.weight_value));
          if (out_data.tare_done !== want.tare_done)
            report_mismatch($sformatf("result %0d tare_done %b, expected %b", results_seen,
                                      out_data.tare_done, want.tare_done));
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("no request moved on any channel for %0d cycles", QUIET_LIMIT);
        $display("load_cell_tare_scale_smoother regression: fail");
        $finish;
      end
    end
  end

  // sender: entered and left at a falling edge; valid stays up after acceptance
  // so that back-to-back requests never lower and raise it in one step
  task automatic push_sample(input in_item_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until every owed result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_weights.size() != 0) @(negedge clk);
  endtask

  // keep leaves valid up when another write follows straight away
  task automatic write_reg(input logic idx, input logic [15:0] val, input bit keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    if (!keep) cfg_valid <= 1'b0;
  endtask

  dir_row_t steps[$];
  int       sent;
  int       base;
  int       roll;
  int       p_sel;
  int       d_sel;

  initial begin
    // directed table: reset state, then full weight with unit divisor so results read
    // straight off the samples, tare at both rails, truncation of negative tare parts,
    // zero weight, percentage above full with stray upper data bits, zero divisor,
    // largest divisor, a half-finished tare, and finally the reset settings again
    steps = '{
      known_row(REQ_MEASURE, 0, 0, 1'b0),
      reg_row(CFG_FILTER_PERCENT, 100),
      reg_row(CFG_SCALE_DIVISOR, 1),
      known_row(REQ_MEASURE, 8388607, 8388607, 1'b0),
      known_row(REQ_MEASURE, -8388608, -8388608, 1'b0),
      known_row(REQ_TARE, -8388608, -8388608, 1'b0),
      known_row(REQ_TARE, -8388608, -8388608, 1'b0),
      known_row(REQ_TARE, -8388608, -8388608, 1'b0),
      known_row(REQ_TARE, -8388608, -8388608, 1'b1),
      known_row(REQ_MEASURE, 8388607, 16777215, 1'b0),
      known_row(REQ_TARE, 8388607, 16777215, 1'b0),
      known_row(REQ_TARE, 8388607, 16777215, 1'b0),
      known_row(REQ_TARE, 8388607, 16777215, 1'b0),
      known_row(REQ_TARE, 8388607, 16777215, 1'b1),
      known_row(REQ_MEASURE, -8388608, -16777212, 1'b0),
      known_row(REQ_TARE, -3, -16777212, 1'b0),
      known_row(REQ_TARE, -3, -16777212, 1'b0),
      known_row(REQ_TARE, -3, -16777212, 1'b0),
      known_row(REQ_TARE, -3, -16777212, 1'b1),
      known_row(REQ_MEASURE, 5, 5, 1'b0),
      reg_row(CFG_FILTER_PERCENT, 0),
      known_row(REQ_MEASURE, 1000, 5, 1'b0),
      reg_row(CFG_FILTER_PERCENT, 16'hFF7F),
      reg_row(CFG_SCALE_DIVISOR, 0),
      known_row(REQ_MEASURE, -7, -7, 1'b0),
      reg_row(CFG_FILTER_PERCENT, 50),
      reg_row(CFG_SCALE_DIVISOR, 65535),
      free_row(REQ_MEASURE, 8388607),
      free_row(REQ_TARE, 123456),
      free_row(REQ_MEASURE, -1),
      reg_row(CFG_FILTER_PERCENT, 10),
      reg_row(CFG_SCALE_DIVISOR, 719)
    };

    // synchronous reset held over the RESET_CYCLES wait, released at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < steps.size(); i++) begin
      if (steps[i].kind == ROW_REG) begin
        drain_results();
        write_reg(steps[i].reg_idx, steps[i].reg_val,
                  (i + 1 < steps.size()) && (steps[i + 1].kind == ROW_REG));
      end else begin
        if (steps[i].typed) begin
          typed_armed = 1'b1;
          typed_want = steps[i].want;
        end
        push_sample(steps[i].rq);
      end
    end

    // random phases: each starts from an empty pipe, takes new settings and an idling mode
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin p_sel = FILTER_RESET; d_sel = SCALE_RESET; end
        1: begin p_sel = 100; d_sel = 1; end
        2: begin p_sel = 0; d_sel = 65535; end
        3: begin p_sel = 127; d_sel = 0; end
        4: begin p_sel = 1; d_sel = 2; end
        default: begin
          p_sel = $urandom_range(0, 127);
          d_sel = $urandom_range(0, 65535);
        end
      endcase
      // spare upper data bits on the percentage write are don't-care
      write_reg(CFG_FILTER_PERCENT, 16'(p_sel) | 16'($urandom_range(0, 511) << FP_W), 1'b1);
      write_reg(CFG_SCALE_DIVISOR, 16'(d_sel), 1'b0);

      // idling mode: none, sender sparse, receiver stalling, both moderately
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          // a full tare run with readings scattered round one level
          base = pick_raw();
          for (int k = 0; k < TARE_SAMPLES_DEF; k++) begin
            push_sample(make_req(REQ_TARE, base + int'($urandom_range(0, 200)) - 100));
            sent++;
          end
        end else if (roll < 20) begin
          // stray tare reading, leaves the tare count part way
          push_sample(make_req(REQ_TARE, pick_raw()));
          sent++;
        end else begin
          push_sample(make_req(REQ_MEASURE, pick_raw()));
          sent++;
        end
      end
    end

    drain_results();
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_weights.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_weights.size()));

    $display("covered %0d sample requests (%0d tare, %0d offsets formed), %0d results checked",
             samples_in, tare_in, offsets_made, results_seen);
    $display("over %0d register writes and %0d random phases; %0d mismatches",
             cfg_writes, PHASES, err_count);
    if (err_count == 0) $display("load_cell_tare_scale_smoother regression: pass");
    else $display("load_cell_tare_scale_smoother regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/core/lcts_pkg.sv
rtl/core/lcts_div.sv
rtl/core/load_cell_tare_scale_smoother.sv
tb/sv/tb.sv
